// ----- hdl/postfix_stack_evaluator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the postfix stack evaluator
// Concurrent checks on clk, disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property that holds at every edge.
`define PSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent now implies consequent on the next edge.
`define PSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSE_ASSERT(label, prop, msg)
`define PSE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Types and codes shared by the postfix stack evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int STACK_DEPTH_DEFAULT    = 16;
    localparam int VARIABLE_COUNT_DEFAULT = 16;

    localparam int DATA_W = 32;

    // commands
    localparam logic [2:0] CMD_ASSIGN   = 3'd0;
    localparam logic [2:0] CMD_PUSH_NUM = 3'd1;
    localparam logic [2:0] CMD_PUSH_VAR = 3'd2;
    localparam logic [2:0] CMD_APPLY    = 3'd3;
    localparam logic [2:0] CMD_END      = 3'd4;

    // operators
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_UNASSIGNED = 2'd1;
    localparam logic [1:0] ST_DIVZERO    = 2'd2;
    localparam logic [1:0] ST_STACK      = 2'd3;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] operand_value;
        logic [3:0]               variable_index;
        logic [2:0]               operator_code;
    } token_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/postfix_stack_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// Postfix integer expression evaluator on a value stack held in a RAM.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Payload
//  token    in   token_valid/token_ready    pse_pkg::token_t
//  result   out  result_valid/result_ready  pse_pkg::result_t
//
//  Token handling: assign, push number and ignored tokens complete on acceptance;
//  push variable adds a variable RAM read; add/sub/mul add a stack RAM read of
//  both operands; divide/remainder add that read, 32 steps of the restoring
//  divider and a sign fix. End waits for the result register to drain.
//  Reset clears state, stack pointer, latched error, variable valid bits and result valid only.
//  Tokens keep flowing while a result waits; an end token holds until the
//  result register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "postfix_stack_evaluator_top_defines.svh"

module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH    = pse_pkg::STACK_DEPTH_DEFAULT,
    parameter int VARIABLE_COUNT = pse_pkg::VARIABLE_COUNT_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             token_valid,
    output logic                  token_ready,
    input  wire pse_pkg::token_t  token,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output pse_pkg::result_t      result
);

    localparam int DW   = pse_pkg::DATA_W;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int VA_W = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VREAD = 3'd1;
    localparam logic [2:0] S_OPRD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DFIX  = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;

    function automatic logic [DW-1:0] magnitude(input logic [DW-1:0] v);
        magnitude = v[DW-1] ? (DW'(0) - v) : v;
    endfunction

    // control registers
    logic [2:0]                state_reg, state_next;
    logic [SP_W-1:0]           sp_reg, sp_next;
    logic [1:0]                err_reg, err_next;
    logic [VARIABLE_COUNT-1:0] var_valid_reg, var_valid_next;
    logic                      result_valid_reg, result_valid_next;

    // payload registers
    pse_pkg::result_t          result_reg, result_next;
    logic [2:0]                op_reg;
    logic [DW-1:0]             var_rd_reg;
    logic [DW-1:0]             rd_a_reg;   // stack[sp-1], right operand / top
    logic [DW-1:0]             rd_b_reg;   // stack[sp-2], left operand
    logic [DW-1:0]             div_q_reg, div_r_reg, div_d_reg;
    logic [4:0]                div_cnt_reg;
    logic                      lneg_reg, rneg_reg;

    logic [DW-1:0] stack_mem [STACK_DEPTH];
    logic [DW-1:0] var_mem   [VARIABLE_COUNT];

    logic            token_fire;
    logic [31:0]     idx_ext;
    logic            var_in_range;
    logic [VA_W-1:0] var_addr;
    logic [SP_W-1:0] sp_dec1, sp_dec2;
    logic            stack_full;
    logic            slot_free;

    logic            st_we;
    logic [SA_W-1:0] st_waddr;
    logic [DW-1:0]   st_wdata;

    logic [DW:0]     div_shift, div_trial;
    logic [DW-1:0]   div_res;

    assign token_ready  = (state_reg == S_IDLE);
    assign token_fire   = token_valid && token_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign idx_ext      = 32'(token.variable_index);
    assign var_in_range = idx_ext < 32'(VARIABLE_COUNT);
    assign var_addr     = idx_ext[VA_W-1:0];

    assign sp_dec1    = sp_reg - SP_W'(1);
    assign sp_dec2    = sp_reg - SP_W'(2);
    assign stack_full = sp_reg >= SP_W'(STACK_DEPTH);
    assign slot_free  = !result_valid_reg || result_ready;

    // one restoring step: shift in next dividend bit, trial subtract
    assign div_shift = {div_r_reg, div_q_reg[DW-1]};
    assign div_trial = div_shift - {1'b0, div_d_reg};

    always_comb
    begin
        if (op_reg == pse_pkg::OP_DIV)
            div_res = (lneg_reg != rneg_reg) ? (DW'(0) - div_q_reg) : div_q_reg;
        else
            div_res = lneg_reg ? (DW'(0) - div_r_reg) : div_r_reg;
    end

    always_comb
    begin
        state_next        = state_reg;
        sp_next           = sp_reg;
        err_next          = err_reg;
        var_valid_next    = var_valid_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        st_we             = 1'b0;
        st_waddr          = sp_reg[SA_W-1:0];
        st_wdata          = token.operand_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (token_fire)
                begin
                    unique case (token.command)
                        pse_pkg::CMD_ASSIGN:
                        begin
                            if (var_in_range)
                                var_valid_next[var_addr] = 1'b1;
                        end
                        pse_pkg::CMD_PUSH_NUM:
                        begin
                            if (err_reg == pse_pkg::ST_OK)
                            begin
                                if (stack_full)
                                    err_next = pse_pkg::ST_STACK;
                                else
                                begin
                                    st_we   = 1'b1;
                                    sp_next = sp_reg + SP_W'(1);
                                end
                            end
                        end
                        pse_pkg::CMD_PUSH_VAR:
                        begin
                            if (err_reg == pse_pkg::ST_OK)
                            begin
                                if (var_in_range && var_valid_reg[var_addr])
                                    state_next = S_VREAD;
                                else
                                    err_next = pse_pkg::ST_UNASSIGNED;
                            end
                        end
                        pse_pkg::CMD_APPLY:
                        begin
                            if (err_reg == pse_pkg::ST_OK &&
                                token.operator_code <= pse_pkg::OP_REM)
                            begin
                                if (sp_reg < SP_W'(2))
                                    err_next = pse_pkg::ST_STACK;
                                else
                                    state_next = S_OPRD;
                            end
                        end
                        pse_pkg::CMD_END:
                        begin
                            state_next = S_END;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_VREAD:
            begin
                if (stack_full)
                    err_next = pse_pkg::ST_STACK;
                else
                begin
                    st_we    = 1'b1;
                    st_wdata = var_rd_reg;
                    sp_next  = sp_reg + SP_W'(1);
                end
                state_next = S_IDLE;
            end
            S_OPRD:
            begin
                st_waddr   = sp_dec2[SA_W-1:0];
                state_next = S_IDLE;
                unique case (op_reg)
                    pse_pkg::OP_ADD:
                    begin
                        st_we    = 1'b1;
                        st_wdata = rd_b_reg + rd_a_reg;
                        sp_next  = sp_dec1;
                    end
                    pse_pkg::OP_SUB:
                    begin
                        st_we    = 1'b1;
                        st_wdata = rd_b_reg - rd_a_reg;
                        sp_next  = sp_dec1;
                    end
                    pse_pkg::OP_MUL:
                    begin
                        st_we    = 1'b1;
                        st_wdata = rd_b_reg * rd_a_reg;
                        sp_next  = sp_dec1;
                    end
                    pse_pkg::OP_DIV, pse_pkg::OP_REM:
                    begin
                        if (rd_a_reg == '0)
                            err_next = pse_pkg::ST_DIVZERO;
                        else
                            state_next = S_DIV;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                    state_next = S_DFIX;
            end
            S_DFIX:
            begin
                st_we      = 1'b1;
                st_waddr   = sp_dec2[SA_W-1:0];
                st_wdata   = div_res;
                sp_next    = sp_dec1;
                state_next = S_IDLE;
            end
            S_END:
            begin
                if (slot_free)
                begin
                    result_valid_next = 1'b1;
                    result_next.status = err_reg;
                    result_next.result_value = '0;
                    if (err_reg == pse_pkg::ST_OK)
                    begin
                        if (sp_reg == '0)
                            result_next.status = pse_pkg::ST_STACK;
                        else
                            result_next.result_value = rd_a_reg;
                    end
                    sp_next    = '0;
                    err_next   = pse_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sp_reg           <= '0;
            err_reg          <= pse_pkg::ST_OK;
            var_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sp_reg           <= sp_next;
            err_reg          <= err_next;
            var_valid_reg    <= var_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (token_fire)
            op_reg <= token.operator_code;
    end

    // stack RAM: one write port, two registered read ports at sp-1 and sp-2
    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[st_waddr] <= st_wdata;
        if (state_reg == S_IDLE)
        begin
            rd_a_reg <= stack_mem[sp_dec1[SA_W-1:0]];
            rd_b_reg <= stack_mem[sp_dec2[SA_W-1:0]];
        end
    end

    // variable RAM
    always_ff @(posedge clk)
    begin
        if (token_fire && token.command == pse_pkg::CMD_ASSIGN && var_in_range)
            var_mem[var_addr] <= token.operand_value;
        if (token_fire)
            var_rd_reg <= var_mem[var_addr];
    end

    // iterative divider on magnitudes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OPRD)
        begin
            div_q_reg   <= magnitude(rd_b_reg);
            div_d_reg   <= magnitude(rd_a_reg);
            div_r_reg   <= '0;
            div_cnt_reg <= '0;
            lneg_reg    <= rd_b_reg[DW-1];
            rneg_reg    <= rd_a_reg[DW-1];
        end
        else if (state_reg == S_DIV)
        begin
            div_cnt_reg <= div_cnt_reg + 5'd1;
            if (!div_trial[DW])
            begin
                div_r_reg <= div_trial[DW-1:0];
                div_q_reg <= {div_q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                div_r_reg <= div_shift[DW-1:0];
                div_q_reg <= {div_q_reg[DW-2:0], 1'b0};
            end
        end
    end

    `PSE_ASSERT(a_sp_bound, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer past depth")
    `PSE_ASSERT(a_err_zero_value,
        (!result_valid_reg || result_reg.status == pse_pkg::ST_OK ||
         result_reg.result_value == '0), "error result carries nonzero value")
    `PSE_ASSERT(a_div_nonzero, (state_reg != S_DIV) || (div_d_reg != '0),
        "divider running on zero divisor")
    `PSE_ASSERT_NEXT(a_end_clears, (state_reg == S_END) && slot_free,
        result_valid_reg && (sp_reg == '0) && (err_reg == pse_pkg::ST_OK),
        "end did not post result and clear state")
    `PSE_ASSERT_NEXT(a_err_holds_stack,
        token_fire && (err_reg != pse_pkg::ST_OK) && (token.command != pse_pkg::CMD_END),
        $stable(sp_reg) && (state_reg == S_IDLE), "token acted after latched error")

endmodule

`default_nettype wire

// ----- tb/tb_postfix_stack_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_top
// Drives postfix token requests into the evaluator with random idle gaps and
// result back-pressure. A token-level model of the stack, the variable table
// and the latched error predicts every end-of-expression result, which is
// checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator_top;

    localparam int         CYCLE_LIMIT  = 400_000;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         ITEM_TARGET  = 950;
    localparam int         MODEL_DEPTH  = pse_pkg::STACK_DEPTH_DEFAULT;
    localparam int         MODEL_VARS   = pse_pkg::VARIABLE_COUNT_DEFAULT;
    localparam logic [2:0] CMD_UNUSED   = 3'd5;
    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam logic [31:0] INT_MIN     = 32'h8000_0000;
    localparam logic [31:0] INT_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] MINUS_ONE   = 32'hFFFF_FFFF;

    logic             clk;
    logic             rst_n;
    logic             token_valid;
    logic             token_ready;
    pse_pkg::token_t  token;
    logic             result_valid;
    logic             result_ready;
    pse_pkg::result_t result;

    // model state
    logic [31:0] stack_words [MODEL_DEPTH];
    int          stack_fill;
    logic [31:0] var_words [MODEL_VARS];
    logic [MODEL_VARS-1:0] var_set;
    logic [1:0]  latched_status;

    pse_pkg::result_t evaluated_results [$];
    int      mismatch_count;
    int      sent_tokens;
    int      cycle_count;
    bit      steady_flow;

    postfix_stack_evaluator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_postfix_stack_evaluator_top: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic latch_status(input logic [1:0] code);
        if (latched_status == pse_pkg::ST_OK)
            latched_status = code;
    endtask

    task automatic push_word(input logic [31:0] v);
        if (stack_fill >= MODEL_DEPTH)
            latch_status(pse_pkg::ST_STACK);
        else
        begin
            stack_words[stack_fill] = v;
            stack_fill++;
        end
    endtask

    // One accepted token through the model; end tokens queue their result.
    task automatic evaluate_token(input pse_pkg::token_t t);
        logic [31:0]      lhs, rhs, ul, ur, res;
        pse_pkg::result_t r;
        case (t.command)
            pse_pkg::CMD_ASSIGN:
            begin
                var_words[t.variable_index] = t.operand_value;
                var_set[t.variable_index]   = 1'b1;
            end
            pse_pkg::CMD_PUSH_NUM:
                if (latched_status == pse_pkg::ST_OK)
                    push_word(t.operand_value);
            pse_pkg::CMD_PUSH_VAR:
                if (latched_status == pse_pkg::ST_OK)
                begin
                    if (var_set[t.variable_index])
                        push_word(var_words[t.variable_index]);
                    else
                        latch_status(pse_pkg::ST_UNASSIGNED);
                end
            pse_pkg::CMD_APPLY:
                if (latched_status == pse_pkg::ST_OK && t.operator_code <= pse_pkg::OP_REM)
                begin
                    if (stack_fill < 2)
                        latch_status(pse_pkg::ST_STACK);
                    else
                    begin
                        rhs = stack_words[stack_fill-1];
                        lhs = stack_words[stack_fill-2];
                        if ((t.operator_code == pse_pkg::OP_DIV ||
                             t.operator_code == pse_pkg::OP_REM) && rhs == 32'd0)
                            latch_status(pse_pkg::ST_DIVZERO);
                        else
                        begin
                            ul = lhs[31] ? 32'd0 - lhs : lhs;
                            ur = rhs[31] ? 32'd0 - rhs : rhs;
                            case (t.operator_code)
                                pse_pkg::OP_ADD: res = lhs + rhs;
                                pse_pkg::OP_SUB: res = lhs - rhs;
                                pse_pkg::OP_MUL: res = lhs * rhs;
                                pse_pkg::OP_DIV:
                                begin
                                    res = ul / ur;
                                    if (lhs[31] != rhs[31])
                                        res = 32'd0 - res;
                                end
                                default:
                                begin
                                    // remainder follows the dividend sign
                                    res = ul % ur;
                                    if (lhs[31])
                                        res = 32'd0 - res;
                                end
                            endcase
                            stack_fill--;
                            stack_words[stack_fill-1] = res;
                        end
                    end
                end
            pse_pkg::CMD_END:
            begin
                r.status       = latched_status;
                r.result_value = '0;
                if (latched_status == pse_pkg::ST_OK)
                begin
                    if (stack_fill == 0)
                        r.status = pse_pkg::ST_STACK;
                    else
                        r.result_value = stack_words[stack_fill-1];
                end
                evaluated_results = {evaluated_results, r};
                stack_fill     = 0;
                latched_status = pse_pkg::ST_OK;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_fill     = 0;
            var_set        = '0;
            latched_status = pse_pkg::ST_OK;
        end
        else if (token_valid && token_ready)
            evaluate_token(token);
    end

    always @(posedge clk)
    begin : check_results
        pse_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (evaluated_results.size() == 0)
                report_mismatch($sformatf("result %0h/%0d with no expression pending",
                                          result.result_value, result.status));
            else
            begin
                want = evaluated_results.pop_front();
                if (result.result_value !== want.result_value)
                    report_mismatch($sformatf("result_value got %0h, want %0h",
                                              result.result_value, want.result_value));
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d, want %0d",
                                              result.status, want.status));
            end
        end
    end

    // result side: random stall before taking each result
    initial
    begin : result_sink
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 19);
            repeat (stall)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    function automatic pse_pkg::token_t random_token();
        pse_pkg::token_t t;
        t.command        = 3'($urandom_range(0, 7));
        t.operand_value  = $urandom;
        t.variable_index = 4'($urandom_range(0, 15));
        t.operator_code  = 3'($urandom_range(0, 7));
        return t;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return 32'd0;
            3: return MINUS_ONE;
            4, 5, 6: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Valid is left high after acceptance; the next request either replaces
    // the payload on the following falling edge or drops valid for its gap.
    task automatic send_token(input pse_pkg::token_t t);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 19);
        repeat (gap)
        begin
            @(negedge clk);
            token_valid <= 1'b0;
        end
        @(negedge clk);
        token_valid <= 1'b1;
        token       <= t;
        do @(posedge clk); while (!token_ready);
        sent_tokens++;
    endtask

    task automatic send_assign(input logic [3:0] idx, input logic [31:0] v);
        pse_pkg::token_t t;
        t                = random_token();
        t.command        = pse_pkg::CMD_ASSIGN;
        t.variable_index = idx;
        t.operand_value  = v;
        send_token(t);
    endtask

    task automatic send_push(input logic [31:0] v);
        pse_pkg::token_t t;
        t               = random_token();
        t.command       = pse_pkg::CMD_PUSH_NUM;
        t.operand_value = v;
        send_token(t);
    endtask

    task automatic send_push_var(input logic [3:0] idx);
        pse_pkg::token_t t;
        t                = random_token();
        t.command        = pse_pkg::CMD_PUSH_VAR;
        t.variable_index = idx;
        send_token(t);
    endtask

    task automatic send_apply(input logic [2:0] op);
        pse_pkg::token_t t;
        t               = random_token();
        t.command       = pse_pkg::CMD_APPLY;
        t.operator_code = op;
        send_token(t);
    endtask

    task automatic send_end();
        pse_pkg::token_t t;
        t         = random_token();
        t.command = pse_pkg::CMD_END;
        send_token(t);
    endtask

    task automatic test_signed_extremes();
        send_assign(4'd0, INT_MIN);
        send_assign(4'd15, MINUS_ONE);
        // most negative / -1 wraps, its remainder is zero
        send_push_var(4'd0);
        send_push_var(4'd15);
        send_apply(pse_pkg::OP_DIV);
        send_push_var(4'd0);
        send_push_var(4'd15);
        send_apply(pse_pkg::OP_REM);
        send_apply(pse_pkg::OP_ADD);
        send_end();
        // add and subtract wrap across the sign boundary
        send_push(INT_MAX);
        send_push(32'd1);
        send_apply(pse_pkg::OP_ADD);
        send_push(32'd1);
        send_apply(pse_pkg::OP_SUB);
        send_push_var(4'd15);
        send_apply(pse_pkg::OP_MUL);
        send_end();
    endtask

    task automatic test_ignored_codes();
        pse_pkg::token_t t;
        send_push(32'd3);
        send_apply(OP_UNUSED);
        t         = random_token();
        t.command = CMD_UNUSED;
        send_token(t);
        send_push(32'd4);
        // two entries left: top is emitted
        send_end();
    endtask

    task automatic test_error_latching();
        send_push(32'd9);
        send_push(32'd0);
        send_apply(pse_pkg::OP_DIV);
        // assign still lands while the error holds, the push is dropped
        send_assign(4'd3, 32'd12);
        send_push_var(4'd3);
        send_end();
        send_push_var(4'd3);
        send_push(32'd0);
        send_apply(pse_pkg::OP_REM);
        send_end();
        send_push(32'd1);
        send_apply(pse_pkg::OP_ADD);
        send_end();
        send_end();
        send_push_var(4'd7);
        send_end();
    endtask

    task automatic test_random_expressions();
        int         operands;
        int         depth;
        int         pushed;
        int         roll;
        bit         deep;
        logic [2:0] op;
        while (sent_tokens < ITEM_TARGET)
        begin
            steady_flow = ($urandom_range(0, 7) == 0);
            roll        = $urandom_range(0, 99);
            if (roll < 8)
            begin
                repeat ($urandom_range(1, 3))
                    send_token(random_token());
            end
            else
            begin
                // deep expressions push everything first and may overflow
                deep     = (roll < 16);
                operands = deep ? $urandom_range(15, 18) : $urandom_range(1, 5);
                depth    = 0;
                pushed   = 0;
                repeat ($urandom_range(0, 2))
                    send_assign(4'($urandom_range(0, 15)), pick_operand());
                while (pushed < operands || depth > 1)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_assign(4'($urandom_range(0, 15)), pick_operand());
                    else if (pushed < operands
                             && (depth < 2 || deep || $urandom_range(0, 1) == 1))
                    begin
                        if ($urandom_range(0, 1) == 1)
                            send_push(pick_operand());
                        else
                            send_push_var(4'($urandom_range(0, 15)));
                        pushed++;
                        depth++;
                    end
                    else
                    begin
                        op = ($urandom_range(0, 14) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4));
                        send_apply(op);
                        if (op <= pse_pkg::OP_REM)
                            depth--;
                    end
                end
                case ($urandom_range(0, 9))
                    0: send_apply(3'($urandom_range(0, 4)));
                    1: send_push(pick_operand());
                    default: ;
                endcase
                send_end();
            end
        end
    endtask

    initial
    begin
        token_valid    = 1'b0;
        token          = '0;
        rst_n          = 1'b0;
        steady_flow    = 1'b0;
        mismatch_count = 0;
        sent_tokens    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_signed_extremes();
        test_ignored_codes();
        test_error_latching();
        test_random_expressions();

        @(negedge clk);
        token_valid <= 1'b0;
        while (evaluated_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_postfix_stack_evaluator_top: PASS");
        else
            $display("tb_postfix_stack_evaluator_top: FAIL");
        $finish;
    end

endmodule
